/* hw/rtl/jctfl_pkg.sv */
// ----------------------------------------------------------------------------
// jctfl_pkg
// Shared types for the job countdown table: controller states and the
// command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package jctfl_pkg;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SERVE  = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  typedef struct packed {
    logic latch;   // capture request fields
    logic serve;   // match, decrement, free slot
    logic finish;  // pop free slot, insert, load result
  } cmd_t;

endpackage

/* hw/rtl/jctfl_ctrl.sv */
// ----------------------------------------------------------------------------
// jctfl_ctrl
// Sequencer for one request: capture, serve step, insert step with result
// hand-off. Owns the result valid flag.
// ----------------------------------------------------------------------------
module jctfl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jctfl_pkg::cmd_t cmd_o
);
  import jctfl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_SERVE;
        end
      end
      S_SERVE: begin
        cmd_o.serve = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/jctfl_dp.sv */
// ----------------------------------------------------------------------------
// jctfl_dp
// Datapath: slot table, free-slot circular queue, no-job register, request
// capture and result register.
// ----------------------------------------------------------------------------
module jctfl_dp #(
  parameter int SLOTS      = 16,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  jctfl_pkg::cmd_t       cmd_i,
  input  logic                  cfg_we_i,
  input  logic [ID_BITS-1:0]    cfg_wdata_i,
  input  logic [ID_BITS-1:0]    served_job_id_i,
  input  logic [ID_BITS-1:0]    new_job_id_i,
  input  logic [COUNT_BITS-1:0] new_job_count_i,
  output logic [ID_BITS-1:0]    result_job_id_o,
  output logic                  action_o,
  output logic                  retired_o
);
  import jctfl_pkg::*;

  localparam int QDEPTH = SLOTS + 1;
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW     = $clog2(QDEPTH);
  localparam logic [ID_BITS-1:0] ID_LOW16 = ID_BITS'(32'h0000_FFFF);

  logic [ID_BITS-1:0]    no_job_q;
  logic [ID_BITS-1:0]    served_q;
  logic [ID_BITS-1:0]    new_id_q;
  logic [COUNT_BITS-1:0] new_cnt_q;

  logic [ID_BITS-1:0]    slot_id_q  [SLOTS];
  logic [COUNT_BITS-1:0] slot_cnt_q [SLOTS];
  logic [QW-1:0]         fq_q       [QDEPTH];
  logic [QW-1:0]         head_q, tail_q;

  logic [ID_BITS-1:0]    res_id_q;
  logic                  act_q;
  logic [ID_BITS-1:0]    out_id_q;
  logic                  out_act_q;

  // serve step
  logic [SLOTS-1:0]      hit;
  logic                  any_hit;
  logic [SW-1:0]         hit_idx;
  logic [COUNT_BITS-1:0] dec_cnt;
  logic                  dec_zero;
  logic [QW-1:0]         tail_nxt;
  logic                  push_ok;

  // insert step
  logic [QW-1:0]         head_nxt;
  logic                  pop_ok;
  logic [QW-1:0]         pop_slot;
  logic                  ins_ok;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = (slot_id_q[i] == served_q);
    end
  end

  // lowest matching index wins
  always_comb begin
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = SW'(i);
    end
  end

  assign any_hit  = (served_q != no_job_q) && (|hit);
  assign dec_cnt  = slot_cnt_q[hit_idx] - COUNT_BITS'(1);
  assign dec_zero = (dec_cnt == '0);
  assign tail_nxt = (tail_q == QW'(SLOTS)) ? '0 : tail_q + QW'(1);
  assign push_ok  = (tail_nxt != head_q);

  assign head_nxt = (head_q == QW'(SLOTS)) ? '0 : head_q + QW'(1);
  assign pop_ok   = (new_id_q != no_job_q) && (head_q != tail_q);
  assign pop_slot = fq_q[head_q];
  assign ins_ok   = pop_ok && (pop_slot < QW'(SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_job_q <= ID_LOW16;
    end else if (cfg_we_i) begin
      no_job_q <= cfg_wdata_i & ID_LOW16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      served_q  <= served_job_id_i;
      new_id_q  <= new_job_id_i;
      new_cnt_q <= new_job_count_i;
    end
    if (cmd_i.serve) begin
      res_id_q <= any_hit ? served_q : no_job_q;
      act_q    <= any_hit && dec_zero;
    end
    if (cmd_i.finish) begin
      out_id_q  <= res_id_q & ID_LOW16;
      out_act_q <= act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id_q[i]  <= ID_LOW16;
        slot_cnt_q[i] <= '0;
      end
    end else if (cmd_i.serve && any_hit) begin
      if (dec_zero) begin
        slot_id_q[hit_idx]  <= no_job_q;
        slot_cnt_q[hit_idx] <= '0;
      end else begin
        slot_cnt_q[hit_idx] <= dec_cnt;
      end
    end else if (cmd_i.finish && ins_ok) begin
      slot_id_q[pop_slot[SW-1:0]]  <= new_id_q;
      slot_cnt_q[pop_slot[SW-1:0]] <= new_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QDEPTH; i++) begin
        fq_q[i] <= (i < SLOTS) ? QW'(i) : '0;
      end
      head_q <= '0;
      tail_q <= QW'(SLOTS);
    end else if (cmd_i.serve && any_hit && dec_zero && push_ok) begin
      fq_q[tail_q] <= QW'(hit_idx);
      tail_q       <= tail_nxt;
    end else if (cmd_i.finish && pop_ok) begin
      head_q <= head_nxt;
    end
  end

  assign result_job_id_o = out_id_q;
  assign action_o        = out_act_q;
  assign retired_o       = out_act_q;

endmodule

/* hw/rtl/job_countdown_table_with_free_list.sv */
// ----------------------------------------------------------------------------
// job_countdown_table_with_free_list
// Job slot table with per-slot countdown and a circular free-slot queue.
// ----------------------------------------------------------------------------
// Each request passes through three controller states: the idle state captures
// it on acceptance, the serve state runs the parallel match over all slots with
// decrement and slot release, and the finish state pops a free slot, inserts
// the new job and loads the result register, which raises the result valid
// flag. The controller handles one request at a time and takes no new request
// until the finish state has run; the input is accepted again while a result
// still waits in the output register, and the insert step waits only while
// that register is full and not being read. One result is returned per request.
module job_countdown_table_with_free_list #(
  parameter int SLOTS      = 16,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ID_BITS-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ID_BITS-1:0]    served_job_id_i,
  input  logic [ID_BITS-1:0]    new_job_id_i,
  input  logic [COUNT_BITS-1:0] new_job_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ID_BITS-1:0]    result_job_id_o,
  output logic                  action_o,
  output logic                  retired_o
);
  import jctfl_pkg::*;

  cmd_t cmd;

  jctfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  jctfl_dp #(
    .SLOTS      (SLOTS),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .served_job_id_i (served_job_id_i),
    .new_job_id_i    (new_job_id_i),
    .new_job_count_i (new_job_count_i),
    .result_job_id_o (result_job_id_o),
    .action_o        (action_o),
    .retired_o       (retired_o)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the job countdown table with its free-slot queue.
// A queue-fed driver offers requests under random idling, a monitor collects
// results under random stalls, and an in-bench model of the slot table,
// countdowns and free queue predicts each result on acceptance. Phases step
// the no-job code through its extremes and an aliased value, including a
// long countdown wrap that pushes onto a full free queue and a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ID_W  = 16;
  localparam int CNT_W = 8;
  localparam int NSLOT = 16;
  localparam int NPOOL = 12;

  typedef struct packed {
    logic [ID_W-1:0]  served;
    logic [ID_W-1:0]  new_id;
    logic [CNT_W-1:0] new_cnt;
  } job_request_t;

  typedef struct packed {
    logic [ID_W-1:0] job_id;
    logic            action;
    logic            retired;
  } job_result_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             cfg_we_i        = 1'b0;
  logic [ID_W-1:0]  cfg_wdata_i     = '0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [ID_W-1:0]  served_job_id_i = '0;
  logic [ID_W-1:0]  new_job_id_i    = '0;
  logic [CNT_W-1:0] new_job_count_i = '0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [ID_W-1:0]  result_job_id_o;
  logic             action_o;
  logic             retired_o;

  job_countdown_table_with_free_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .served_job_id_i (served_job_id_i),
    .new_job_id_i    (new_job_id_i),
    .new_job_count_i (new_job_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_job_id_o (result_job_id_o),
    .action_o        (action_o),
    .retired_o       (retired_o)
  );

  always #5 clk_i = ~clk_i;

  job_request_t    pending_requests[$];
  job_result_t     awaited_results[$];
  int              failures       = 0;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              phase_no       = 0;
  logic            rx_hold        = 1'b0;
  logic [ID_W-1:0] job_pool[NPOOL];

  // model of the slot table and free queue
  logic [ID_W-1:0]  no_job_model;
  logic [ID_W-1:0]  slot_id_model[NSLOT];
  logic [CNT_W-1:0] slot_cnt_model[NSLOT];
  int unsigned      free_slots[NSLOT+1];
  int unsigned      free_head;
  int unsigned      free_tail;

  function automatic int unsigned ring_next(input int unsigned p);
    return (p >= NSLOT) ? 0 : p + 1;
  endfunction

  function automatic job_result_t serve_and_insert(input logic [ID_W-1:0] served,
                                                   input logic [ID_W-1:0] new_id,
                                                   input logic [CNT_W-1:0] new_cnt);
    job_result_t      r;
    logic [CNT_W-1:0] c;
    int unsigned      nt;
    int unsigned      s;
    int               i;
    bit               hit;
    r.job_id  = no_job_model;
    r.action  = 1'b0;
    r.retired = 1'b0;
    hit = 1'b0;
    if (served != no_job_model) begin
      for (i = 0; i < NSLOT; i++) begin
        if (!hit && slot_id_model[i] == served) begin
          hit = 1'b1;
          c = slot_cnt_model[i] - 1'b1;
          r.job_id = served;
          if (c == '0) begin
            slot_id_model[i]  = no_job_model;
            slot_cnt_model[i] = '0;
            nt = ring_next(free_tail);
            // full free queue drops the push
            if (nt != free_head) begin
              free_slots[free_tail] = i;
              free_tail = nt;
            end
            r.action  = 1'b1;
            r.retired = 1'b1;
          end else begin
            slot_cnt_model[i] = c;
          end
        end
      end
    end
    if (new_id != no_job_model && free_head != free_tail) begin
      s = free_slots[free_head];
      free_head = ring_next(free_head);
      if (s < NSLOT) begin
        slot_id_model[s]  = new_id;
        slot_cnt_model[s] = new_cnt;
      end
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        awaited_results.push_back(serve_and_insert(served_job_id_i, new_job_id_i,
                                                   new_job_count_i));
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          served_job_id_i <= pending_requests[0].served;
          new_job_id_i    <= pending_requests[0].new_id;
          new_job_count_i <= pending_requests[0].new_cnt;
          void'(pending_requests.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    job_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: job_id %h", result_job_id_o);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (result_job_id_o !== want.job_id) begin
            $error("result_job_id: expected %h, actual %h", want.job_id, result_job_id_o);
            failures++;
          end
          if (action_o !== want.action) begin
            $error("action: expected %b, actual %b", want.action, action_o);
            failures++;
          end
          if (retired_o !== want.retired) begin
            $error("retired: expected %b, actual %b", want.retired, retired_o);
            failures++;
          end
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (phase_no == 3);
    repeat (20) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (90) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic add_request(input logic [ID_W-1:0] served, input logic [ID_W-1:0] new_id,
                             input logic [CNT_W-1:0] new_cnt);
    job_request_t rq;
    rq.served  = served;
    rq.new_id  = new_id;
    rq.new_cnt = new_cnt;
    pending_requests.push_back(rq);
  endtask

  task automatic add_random_requests(input int n, input int ins_pct, input int srv_pct);
    logic [ID_W-1:0]  s;
    logic [ID_W-1:0]  nid;
    logic [CNT_W-1:0] c;
    int               k;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < srv_pct) s = job_pool[$urandom_range(NPOOL-1)];
      else if (k < srv_pct + 8) s = no_job_model;
      else s = ID_W'($urandom);
      k = $urandom_range(99);
      nid = (k < ins_pct) ? job_pool[$urandom_range(NPOOL-1)] : no_job_model;
      k = $urandom_range(99);
      if (k < 65) c = CNT_W'($urandom_range(4, 1));
      else if (k < 72) c = '0;
      else if (k < 79) c = '1;
      else if (k < 92) c = CNT_W'($urandom_range(40, 5));
      else c = CNT_W'($urandom);
      add_request(s, nid, c);
    end
  endtask

  task automatic write_no_job_code(input logic [ID_W-1:0] code);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    no_job_model = code;
  endtask

  task automatic drain_requests();
    while (pending_requests.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int i;
    no_job_model = '1;
    for (i = 0; i < NSLOT; i++) begin
      slot_id_model[i]  = '1;
      slot_cnt_model[i] = '0;
      free_slots[i]     = i;
    end
    free_slots[NSLOT] = 0;
    free_head = 0;
    free_tail = NSLOT;
    for (i = 0; i < NPOOL; i++)
      job_pool[i] = ID_W'($urandom_range(16'hFFFE, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero code: empty slots still hold all ones, countdown wraps through
    // the full range and the final release hits a full free queue
    phase_no = 1;
    write_no_job_code('0);
    set_idling(0, 48);
    repeat (258) add_request('1, '0, CNT_W'($urandom));
    drain_requests();

    // directed requests under the reset code
    phase_no = 2;
    write_no_job_code('1);
    set_idling(0, 0);
    add_request('1, '1, '0);
    add_request(16'h1234, 16'hA5A5, 8'd2);
    add_request('1, 16'hA5A5, 8'd1);
    add_request(16'hA5A5, '1, '0);
    add_request(16'hA5A5, '1, '0);
    add_request(16'hA5A5, 16'h5A5A, '0);
    add_request(16'h5A5A, '1, '0);
    add_request('1, '0, '1);
    add_request('0, 16'hFFFE, 8'd1);
    add_request(16'hFFFE, 16'hFFFE, 8'd128);
    for (i = 0; i < 14; i++)
      add_request('1, ID_W'(16'h7F00 + i), 8'd1);
    drain_requests();

    // insert-heavy traffic with a long output hold-off
    phase_no = 3;
    set_idling(48, 0);
    add_random_requests(170, 80, 50);
    drain_requests();

    // code aliased onto a live job id
    phase_no = 4;
    write_no_job_code(job_pool[3]);
    set_idling(18, 18);
    add_random_requests(170, 50, 80);
    drain_requests();

    phase_no = 5;
    write_no_job_code('1);
    set_idling(0, 0);
    add_random_requests(40, 60, 75);
    drain_requests();

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
